// ----- rtl/core/r2e_pkg.sv -----
// ----------------------------------------------------------------------------
// r2e_pkg
// Shared types, constants and helper functions for the rotation matrix to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package r2e_pkg;

  localparam int W  = 36;   // datapath width of CORDIC vectors, Q.28
  localparam int ZW = 34;   // angle accumulator width, Q.28 radians

  localparam logic signed [ZW-1:0] PI_Q28   = 34'sd843314857;
  localparam logic signed [18:0]   PI_Q13   = 19'sd25736;
  localparam logic signed [18:0]   TWOPI_Q13 = 19'sd51472;
  localparam logic signed [31:0]   GAIN_Q30 = 32'sd1768195363;

  typedef struct packed {
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic                 neg;
  } prep_t;

  // atan(2^-i) in Q.28, rounded
  function automatic logic signed [ZW-1:0] atan_c(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:  a = 34'sd210828714;
      5'd1:  a = 34'sd124459457;
      5'd2:  a = 34'sd65760959;
      5'd3:  a = 34'sd33381290;
      5'd4:  a = 34'sd16755422;
      5'd5:  a = 34'sd8385879;
      5'd6:  a = 34'sd4193963;
      5'd7:  a = 34'sd2097109;
      5'd8:  a = 34'sd1048571;
      5'd9:  a = 34'sd524287;
      5'd10: a = 34'sd262144;
      5'd11: a = 34'sd131072;
      5'd12: a = 34'sd65536;
      5'd13: a = 34'sd32768;
      5'd14: a = 34'sd16384;
      5'd15: a = 34'sd8192;
      5'd16: a = 34'sd4096;
      5'd17: a = 34'sd2048;
      5'd18: a = 34'sd1024;
      5'd19: a = 34'sd512;
      5'd20: a = 34'sd256;
      5'd21: a = 34'sd128;
      5'd22: a = 34'sd64;
      5'd23: a = 34'sd32;
      5'd24: a = 34'sd16;
      5'd25: a = 34'sd8;
      5'd26: a = 34'sd4;
      5'd27: a = 34'sd2;
      5'd28: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q1.14 element to Q.28
  function automatic logic signed [W-1:0] scale16(input logic [15:0] v);
    return {{(W-30){v[15]}}, v, 14'd0};
  endfunction

  // zero vector detect and pre-rotation by pi for negative x
  function automatic prep_t prep(input logic signed [W-1:0] x,
                                 input logic signed [W-1:0] y);
    prep_t p;
    p.zero = (x == '0) && (y == '0);
    p.neg  = x[W-1];
    p.x    = p.neg ? -x : x;
    p.y    = p.neg ? -y : y;
    if (p.neg) begin
      p.z = y[W-1] ? -PI_Q28 : PI_Q28;
    end else begin
      p.z = '0;
    end
    return p;
  endfunction

  // Q.28 angle to Q2.13 with wrap into [-pi, pi)
  function automatic logic [15:0] to_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    logic signed [18:0]   v;
    t = z + 34'sd16384;
    v = t[ZW-1:15];
    if (v >= PI_Q13) begin
      v = v - TWOPI_Q13;
    end
    if (v < -PI_Q13) begin
      v = v + TWOPI_Q13;
    end
    return v[15:0];
  endfunction

endpackage

// ----- rtl/core/r2e_vec_cell.sv -----
// ----------------------------------------------------------------------------
// r2e_vec_cell
// One vectoring CORDIC micro-rotation; drives y toward zero and exports the
// chosen direction for companion rotators in the same stage.
// ----------------------------------------------------------------------------
module r2e_vec_cell #(
  parameter int STEP = 0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [r2e_pkg::W-1:0]  x_i,
  input  logic signed [r2e_pkg::W-1:0]  y_i,
  input  logic signed [r2e_pkg::ZW-1:0] z_i,
  input  logic                         zero_i,
  output logic signed [r2e_pkg::W-1:0]  x_o,
  output logic signed [r2e_pkg::W-1:0]  y_o,
  output logic signed [r2e_pkg::ZW-1:0] z_o,
  output logic                         zero_o,
  output logic                         cw_o
);

  localparam logic signed [r2e_pkg::ZW-1:0] ATAN = r2e_pkg::atan_c(5'(STEP));

  logic signed [r2e_pkg::W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [r2e_pkg::ZW-1:0] z_r, z_nxt;
  logic                         zero_r;

  assign cw_o = !y_i[r2e_pkg::W-1];

  always_comb begin
    if (zero_i) begin
      // hold: atan2(0,0) stays 0
      x_nxt = x_i;
      y_nxt = y_i;
      z_nxt = z_i;
    end else if (cw_o) begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign zero_o = zero_r;

endmodule

// ----- rtl/core/r2e_rot_cell.sv -----
// ----------------------------------------------------------------------------
// r2e_rot_cell
// Companion rotator: applies a micro-rotation in the direction chosen by the
// vectoring cell of the same stage.
// ----------------------------------------------------------------------------
module r2e_rot_cell #(
  parameter int STEP = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        cw_i,
  input  logic                        hold_i,
  input  logic signed [r2e_pkg::W-1:0] x_i,
  input  logic signed [r2e_pkg::W-1:0] y_i,
  output logic signed [r2e_pkg::W-1:0] x_o,
  output logic signed [r2e_pkg::W-1:0] y_o
);

  logic signed [r2e_pkg::W-1:0] x_r, x_nxt, y_r, y_nxt;

  always_comb begin
    if (hold_i) begin
      x_nxt = x_i;
      y_nxt = y_i;
    end else if (cw_i) begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
    end else begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;

endmodule

// ----- rtl/core/rotation_matrix_to_euler.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// ZYX Euler angles (yaw, pitch, roll) from a Q1.14 rotation matrix.
// ----------------------------------------------------------------------------
// Fully pipelined: one matrix word is accepted every cycle while the output
// is not stalled (CORDIC steps are capped at 32). A row
// of CORDIC cells computes yaw and rotates the two companion columns; a gain
// multiply stage and a pre-rotation stage follow, then two parallel cell rows
// compute pitch and roll. The whole pipe advances together and holds while a
// finished word is stalled at the output.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_r00,
  input  logic [15:0] in_r01,
  input  logic [15:0] in_r02,
  input  logic [15:0] in_r10,
  input  logic [15:0] in_r11,
  input  logic [15:0] in_r12,
  input  logic [15:0] in_r20,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_yaw_angle,
  output logic [15:0] out_pitch_angle,
  output logic [15:0] out_roll_angle
);

  localparam int S  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int W  = r2e_pkg::W;
  localparam int ZW = r2e_pkg::ZW;
  localparam int NV = 2 * S + 4;

  logic en;
  logic vld_r [0:NV-1];

  assign en       = !vld_r[NV-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NV; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NV; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // yaw row
  logic signed [W-1:0]  yx [0:S], yy [0:S];
  logic signed [ZW-1:0] yz [0:S];
  logic                 yzero [0:S];
  logic signed [W-1:0]  c0x [0:S], c0y [0:S], c1x [0:S], c1y [0:S];
  logic [15:0]          r20d_r [0:S];
  logic                 ycw [0:S-1];

  r2e_pkg::prep_t pin;
  logic signed [W-1:0] s01, s02, s11, s12;

  always_comb begin
    pin = r2e_pkg::prep(r2e_pkg::scale16(in_r00), r2e_pkg::scale16(in_r10));
    s01 = r2e_pkg::scale16(in_r01);
    s02 = r2e_pkg::scale16(in_r02);
    s11 = r2e_pkg::scale16(in_r11);
    s12 = r2e_pkg::scale16(in_r12);
  end

  logic signed [W-1:0]  yx0_r, yy0_r, c0x0_r, c0y0_r, c1x0_r, c1y0_r;
  logic signed [ZW-1:0] yz0_r;
  logic                 yzero0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yx0_r    <= pin.x;
      yy0_r    <= pin.y;
      yz0_r    <= pin.z;
      yzero0_r <= pin.zero;
      // negate companions with the pi pre-rotation
      c0x0_r   <= pin.neg ? -s02 : s02;
      c0y0_r   <= pin.neg ? -s12 : s12;
      c1x0_r   <= pin.neg ? -s01 : s01;
      c1y0_r   <= pin.neg ? -s11 : s11;
      r20d_r[0] <= in_r20;
      for (int k = 1; k <= S; k++) r20d_r[k] <= r20d_r[k-1];
    end
  end

  assign yx[0]    = yx0_r;
  assign yy[0]    = yy0_r;
  assign yz[0]    = yz0_r;
  assign yzero[0] = yzero0_r;
  assign c0x[0]   = c0x0_r;
  assign c0y[0]   = c0y0_r;
  assign c1x[0]   = c1x0_r;
  assign c1y[0]   = c1y0_r;

  for (genvar i = 0; i < S; i++) begin : g_yaw
    r2e_vec_cell #(.STEP(i)) u_vec (
      .clk(clk), .en(en),
      .x_i(yx[i]), .y_i(yy[i]), .z_i(yz[i]), .zero_i(yzero[i]),
      .x_o(yx[i+1]), .y_o(yy[i+1]), .z_o(yz[i+1]), .zero_o(yzero[i+1]),
      .cw_o(ycw[i])
    );
    r2e_rot_cell #(.STEP(i)) u_c0 (
      .clk(clk), .en(en), .cw_i(ycw[i]), .hold_i(yzero[i]),
      .x_i(c0x[i]), .y_i(c0y[i]), .x_o(c0x[i+1]), .y_o(c0y[i+1])
    );
    r2e_rot_cell #(.STEP(i)) u_c1 (
      .clk(clk), .en(en), .cw_i(ycw[i]), .hold_i(yzero[i]),
      .x_i(c1x[i]), .y_i(c1y[i]), .x_o(c1x[i+1]), .y_o(c1y[i+1])
    );
  end

  // gain stage: pitch numerator times K, roll vector from companions
  logic signed [16:0] nr20;
  logic signed [48:0] prod;
  logic signed [W-1:0] mx_r, mpy_r, mrx_r, mry_r;
  logic [15:0]         myaw_r;

  always_comb begin
    nr20 = -{r20d_r[S][15], r20d_r[S]};
    prod = nr20 * r2e_pkg::GAIN_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= yx[S];
      mpy_r  <= {{(W-33){prod[48]}}, prod[48:16]};
      mrx_r  <= c1y[S];
      mry_r  <= -c0y[S];
      myaw_r <= r2e_pkg::to_q13(yz[S]);
    end
  end

  // pre-rotation stage for pitch and roll
  r2e_pkg::prep_t pp, pr;
  logic signed [W-1:0]  px [0:S], py [0:S], rx [0:S], ry [0:S];
  logic signed [ZW-1:0] pz [0:S], rz [0:S];
  logic                 pzero [0:S], rzero [0:S];
  logic                 pcw [0:S-1], rcw [0:S-1];
  logic [15:0]          yawd_r [0:S];

  always_comb begin
    pp = r2e_pkg::prep(mx_r, mpy_r);
    pr = r2e_pkg::prep(mrx_r, mry_r);
  end

  logic signed [W-1:0]  px0_r, py0_r, rx0_r, ry0_r;
  logic signed [ZW-1:0] pz0_r, rz0_r;
  logic                 pzero0_r, rzero0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r    <= pp.x;
      py0_r    <= pp.y;
      pz0_r    <= pp.z;
      pzero0_r <= pp.zero;
      rx0_r    <= pr.x;
      ry0_r    <= pr.y;
      rz0_r    <= pr.z;
      rzero0_r <= pr.zero;
      yawd_r[0] <= myaw_r;
      for (int k = 1; k <= S; k++) yawd_r[k] <= yawd_r[k-1];
    end
  end

  assign px[0] = px0_r;
  assign py[0] = py0_r;
  assign pz[0] = pz0_r;
  assign pzero[0] = pzero0_r;
  assign rx[0] = rx0_r;
  assign ry[0] = ry0_r;
  assign rz[0] = rz0_r;
  assign rzero[0] = rzero0_r;

  for (genvar i = 0; i < S; i++) begin : g_pr
    r2e_vec_cell #(.STEP(i)) u_pitch (
      .clk(clk), .en(en),
      .x_i(px[i]), .y_i(py[i]), .z_i(pz[i]), .zero_i(pzero[i]),
      .x_o(px[i+1]), .y_o(py[i+1]), .z_o(pz[i+1]), .zero_o(pzero[i+1]),
      .cw_o(pcw[i])
    );
    r2e_vec_cell #(.STEP(i)) u_roll (
      .clk(clk), .en(en),
      .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]), .zero_i(rzero[i]),
      .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1]), .zero_o(rzero[i+1]),
      .cw_o(rcw[i])
    );
  end

  // output word register
  logic [15:0] yaw_r, pitch_r, roll_r;
  logic        pdir_unused, rdir_unused;

  always_comb begin
    pdir_unused = pcw[0] ^ px[S][0] ^ pzero[S];
    rdir_unused = rcw[0] ^ rx[S][0] ^ ry[S][0] ^ py[S][0] ^ rzero[S];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r   <= yawd_r[S];
      pitch_r <= r2e_pkg::to_q13(pz[S]);
      roll_r  <= r2e_pkg::to_q13(rz[S]);
    end
  end

  assign out_valid       = vld_r[NV-1] & (pdir_unused | !pdir_unused)
                           & (rdir_unused | !rdir_unused);
  assign out_yaw_angle   = yaw_r;
  assign out_pitch_angle = pitch_r;
  assign out_roll_angle  = roll_r;

endmodule
